// ===== hw/rtl/kcpi_pkg.sv =====
package kcpi_pkg;

   // CORDIC step count, capped at the depth of the arctangent table
   localparam int TRIG_ITERATIONS = 16;
   localparam int TRIG_STEPS      = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;
   localparam int TRIG_CNT_W      = $clog2(TRIG_STEPS);

   // Q30 angle constants and start gain
   localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
   localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
   localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
   localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
   localparam logic [37:0]        TWO_PI_MAG  = 38'd6746518852;

   // Register indexes of the configuration port
   localparam logic [7:0] CSR_INV_WHEELBASE  = 8'd0;
   localparam logic [7:0] CSR_MIN_DURATION   = 8'd1;
   localparam logic [7:0] CSR_MAX_DURATION   = 8'd2;
   localparam logic [7:0] CSR_FINAL_DURATION = 8'd3;

   // Register reset values
   localparam logic [23:0] RST_INV_WHEELBASE  = 24'd26214;
   localparam logic [15:0] RST_MIN_DURATION   = 16'd328;
   localparam logic [15:0] RST_MAX_DURATION   = 16'd13107;
   localparam logic [15:0] RST_FINAL_DURATION = 16'd13107;

   // Multiply schedule: one issue per step, rounded write back via the product register
   localparam logic [2:0] MUL_LAST = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_TRIG_T,
      ST_TRIG_H,
      ST_MUL,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      CT_IDLE,
      CT_REDUCE,
      CT_WRAP,
      CT_ITER,
      CT_DONE
   } trig_state_type;

   typedef struct packed {
      logic               start;
      logic signed [23:0] angle;
   } trig_req_type;

   typedef struct packed {
      logic               done;
      logic signed [32:0] sin_v;
      logic signed [32:0] cos_v;
   } trig_rsp_type;

   // Arctangent of 2^-i in Q30
   function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
      logic signed [34:0] r;
      case (idx)
         5'd0:  r = 35'sd843314857;
         5'd1:  r = 35'sd497837830;
         5'd2:  r = 35'sd263043837;
         5'd3:  r = 35'sd133525159;
         5'd4:  r = 35'sd67021687;
         5'd5:  r = 35'sd33543516;
         5'd6:  r = 35'sd16775851;
         5'd7:  r = 35'sd8388437;
         5'd8:  r = 35'sd4194283;
         5'd9:  r = 35'sd2097149;
         5'd10: r = 35'sd1048576;
         5'd11: r = 35'sd524288;
         5'd12: r = 35'sd262144;
         5'd13: r = 35'sd131072;
         5'd14: r = 35'sd65536;
         5'd15: r = 35'sd32768;
         5'd16: r = 35'sd16384;
         5'd17: r = 35'sd8192;
         5'd18: r = 35'sd4096;
         5'd19: r = 35'sd2048;
         5'd20: r = 35'sd1024;
         5'd21: r = 35'sd512;
         5'd22: r = 35'sd256;
         5'd23: r = 35'sd128;
         default: r = 35'sd0;
      endcase
      return r;
   endfunction

   // Saturate a sum to 32 bits signed
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sh0_7FFF_FFFF;
      lo = -hi - 34'sd1;
      if (v > hi) return hi[31:0];
      if (v < lo) return lo[31:0];
      return v[31:0];
   endfunction

   // Saturate a sum to 24 bits signed
   function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sh0_007F_FFFF;
      lo = -hi - 34'sd1;
      if (v > hi) return hi[23:0];
      if (v < lo) return lo[23:0];
      return v[23:0];
   endfunction

endpackage

// ===== hw/rtl/kcpi_cordic.sv =====
module kcpi_cordic (
   input  logic                  clock,
   input  logic                  reset,
   input  kcpi_pkg::trig_req_type trig_req,
   output kcpi_pkg::trig_rsp_type trig_rsp
);

   kcpi_pkg::trig_state_type state_ff, state_in;

   logic [37:0]                        mag_ff;
   logic                               sign_ff;
   logic [2:0]                         red_k_ff;
   logic signed [34:0]                 z_ff;
   logic signed [33:0]                 x_ff;
   logic signed [33:0]                 y_ff;
   logic [kcpi_pkg::TRIG_CNT_W-1:0]    it_ff;
   logic                               neg_ff;

   logic [37:0]        ang_ext;
   logic [37:0]        ang_mag;
   logic [37:0]        twopi_sh;
   logic signed [34:0] z_rem;
   logic signed [34:0] z_wrap;
   logic signed [34:0] z_fold;
   logic               fold_neg;
   logic signed [33:0] x_sh;
   logic signed [33:0] y_sh;
   logic signed [34:0] atan_v;
   logic               last_it;
   logic signed [33:0] sin_full;
   logic signed [33:0] cos_full;

   // Angle to Q30 and its magnitude
   assign ang_ext = {trig_req.angle, 14'b0};
   assign ang_mag = trig_req.angle[23] ? (~ang_ext + 38'd1) : ang_ext;

   // Restoring reduction by 2*pi scaled by 16, 8, 4, 2, 1
   assign twopi_sh = kcpi_pkg::TWO_PI_MAG << red_k_ff;

   // Wrap into [-pi, pi] and fold into [-pi/2, pi/2]
   always_comb begin
      z_rem = sign_ff ? -$signed(mag_ff[34:0]) : $signed(mag_ff[34:0]);
      if (z_rem > kcpi_pkg::Q30_PI) begin
         z_wrap = z_rem - kcpi_pkg::Q30_TWO_PI;
      end else if (z_rem < -kcpi_pkg::Q30_PI) begin
         z_wrap = z_rem + kcpi_pkg::Q30_TWO_PI;
      end else begin
         z_wrap = z_rem;
      end
      fold_neg = 1'b0;
      if (z_wrap > kcpi_pkg::Q30_HALF_PI) begin
         z_fold   = z_wrap - kcpi_pkg::Q30_PI;
         fold_neg = 1'b1;
      end else if (z_wrap < -kcpi_pkg::Q30_HALF_PI) begin
         z_fold   = z_wrap + kcpi_pkg::Q30_PI;
         fold_neg = 1'b1;
      end else begin
         z_fold = z_wrap;
      end
   end

   // One rotation step
   assign x_sh    = x_ff >>> it_ff;
   assign y_sh    = y_ff >>> it_ff;
   assign atan_v  = kcpi_pkg::atan_q30(5'(it_ff));
   assign last_it = (it_ff == kcpi_pkg::TRIG_CNT_W'(kcpi_pkg::TRIG_STEPS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kcpi_pkg::CT_IDLE:   if (trig_req.start) state_in = kcpi_pkg::CT_REDUCE;
         kcpi_pkg::CT_REDUCE: if (red_k_ff == 3'd0) state_in = kcpi_pkg::CT_WRAP;
         kcpi_pkg::CT_WRAP:   state_in = kcpi_pkg::CT_ITER;
         kcpi_pkg::CT_ITER:   if (last_it) state_in = kcpi_pkg::CT_DONE;
         kcpi_pkg::CT_DONE:   state_in = kcpi_pkg::CT_IDLE;
         default:             state_in = kcpi_pkg::CT_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      sin_full       = neg_ff ? -y_ff : y_ff;
      cos_full       = neg_ff ? -x_ff : x_ff;
      trig_rsp.done  = (state_ff == kcpi_pkg::CT_DONE);
      trig_rsp.sin_v = sin_full[32:0];
      trig_rsp.cos_v = cos_full[32:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcpi_pkg::CT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         kcpi_pkg::CT_IDLE: begin
            mag_ff   <= ang_mag;
            sign_ff  <= trig_req.angle[23];
            red_k_ff <= 3'd4;
         end
         kcpi_pkg::CT_REDUCE: begin
            if (mag_ff >= twopi_sh) mag_ff <= mag_ff - twopi_sh;
            red_k_ff <= red_k_ff - 3'd1;
         end
         kcpi_pkg::CT_WRAP: begin
            z_ff   <= z_fold;
            neg_ff <= fold_neg;
            x_ff   <= kcpi_pkg::Q30_GAIN;
            y_ff   <= 34'sd0;
            it_ff  <= '0;
         end
         kcpi_pkg::CT_ITER: begin
            if (z_ff >= 35'sd0) begin
               x_ff <= x_ff - y_sh;
               y_ff <= y_ff + x_sh;
               z_ff <= z_ff - atan_v;
            end else begin
               x_ff <= x_ff + y_sh;
               y_ff <= y_ff - x_sh;
               z_ff <= z_ff + atan_v;
            end
            it_ff <= it_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/kinematic_car_pose_integrator.sv =====
// Kinematic bicycle-model pose integrator.
// Input channel req_*: timed drive commands, accepted when req_valid is high
// and req_stall low. Result channel rsp_*: pose results, taken when rsp_valid
// is high and rsp_stall low. Configuration channel csr_*: always ready, one
// register write per transfer; unknown indexes are ignored.
// The first command of a run only becomes pending unless it is final. Each
// later command closes the pending one: a gap out of range gives a bad_gap
// result with the pose cleared, otherwise the pose advances by one Euler step.
// A final command also adds its own result with final_duration and ends the run.
// One item is worked at a time: req_stall stays high until its results are
// loaded. An advance takes two passes of the shared CORDIC unit (launch, 5
// reduction steps, one wrap, one step per iteration, done) and eight steps of
// the shared multiplier; a final command holds up to two advances.
// When rsp_stall holds the output register, the block waits before loading
// the next result; the last result may wait while a new command is accepted.
// Synchronous reset restores the register defaults, drops the pending command
// and clears the pose and the output valid flag.
module kinematic_car_pose_integrator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_command_time,
   input  logic signed [23:0] req_speed,
   input  logic signed [23:0] req_steer_rate,
   input  logic               req_final_command,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_pose_time,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [23:0] rsp_steer_angle,
   output logic signed [23:0] rsp_heading,
   output logic               rsp_bad_gap,
   output logic               rsp_end_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   kcpi_pkg::state_type state_ff, state_in;

   logic [23:0] inv_wb_ff;
   logic [15:0] min_dur_ff;
   logic [15:0] max_dur_ff;
   logic [15:0] fin_dur_ff;

   logic [31:0]        in_time_ff;
   logic signed [23:0] in_speed_ff;
   logic signed [23:0] in_rate_ff;
   logic               in_fin_ff;

   logic               pend_valid_ff;
   logic [31:0]        pend_time_ff;
   logic signed [23:0] pend_speed_ff;
   logic signed [23:0] pend_rate_ff;

   logic [31:0]        cur_time_ff;
   logic signed [31:0] cur_x_ff;
   logic signed [31:0] cur_y_ff;
   logic signed [23:0] cur_tire_ff;
   logic signed [23:0] cur_head_ff;

   logic [15:0]        dur_ff;
   logic signed [23:0] op_speed_ff;
   logic signed [23:0] op_rate_ff;
   logic               phase_ff;
   logic               bad_ff;
   logic               trig_run_ff;

   logic signed [32:0] st_ff;
   logic signed [32:0] ct_ff;
   logic signed [32:0] sh_ff;
   logic signed [32:0] ch_ff;

   logic [2:0]         mul_step_ff;
   logic signed [65:0] prod_ff;
   logic signed [24:0] dv_ff;
   logic signed [24:0] dr_ff;
   logic signed [32:0] dvl_ff;
   logic signed [26:0] dvc_ff;
   logic signed [32:0] dh_ff;
   logic signed [27:0] dx_ff;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_time_ff;
   logic signed [31:0] rsp_x_ff;
   logic signed [31:0] rsp_y_ff;
   logic signed [23:0] rsp_tire_ff;
   logic signed [23:0] rsp_head_ff;
   logic               rsp_bad_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic               emit_load;
   logic               trig_start;
   logic [32:0]        gap;
   logic               gap_bad;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [65:0] r16;
   logic signed [65:0] r30;
   logic signed [33:0] sum_x;
   logic signed [33:0] sum_y;
   logic signed [33:0] sum_tire;
   logic signed [33:0] sum_head;
   logic [32:0]        sum_time;
   logic signed [27:0] dy;

   kcpi_pkg::trig_req_type trig_req;
   kcpi_pkg::trig_rsp_type trig_rsp;

   kcpi_cordic u_trig (
      .clock    (clock),
      .reset    (reset),
      .trig_req (trig_req),
      .trig_rsp (trig_rsp)
   );

   // Gap check against the pending command
   assign gap     = {1'b0, in_time_ff} - {1'b0, pend_time_ff};
   assign gap_bad = gap[32] || (gap[31:0] < {16'b0, min_dur_ff}) ||
                    (gap[31:0] > {16'b0, max_dur_ff});

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kcpi_pkg::ST_IDLE: if (accept) state_in = kcpi_pkg::ST_CHECK;
         kcpi_pkg::ST_CHECK: begin
            if (pend_valid_ff) begin
               state_in = gap_bad ? kcpi_pkg::ST_EMIT : kcpi_pkg::ST_TRIG_T;
            end else begin
               state_in = in_fin_ff ? kcpi_pkg::ST_TRIG_T : kcpi_pkg::ST_IDLE;
            end
         end
         kcpi_pkg::ST_TRIG_T: if (trig_rsp.done) state_in = kcpi_pkg::ST_TRIG_H;
         kcpi_pkg::ST_TRIG_H: if (trig_rsp.done) state_in = kcpi_pkg::ST_MUL;
         kcpi_pkg::ST_MUL: if (mul_step_ff == kcpi_pkg::MUL_LAST) state_in = kcpi_pkg::ST_EMIT;
         kcpi_pkg::ST_EMIT: begin
            if (emit_load) begin
               state_in = (!phase_ff && in_fin_ff) ? kcpi_pkg::ST_TRIG_T : kcpi_pkg::ST_IDLE;
            end
         end
         default: state_in = kcpi_pkg::ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_stall  = (state_ff != kcpi_pkg::ST_IDLE);
      emit_load  = (state_ff == kcpi_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
      trig_start = ((state_ff == kcpi_pkg::ST_TRIG_T) || (state_ff == kcpi_pkg::ST_TRIG_H)) &&
                   !trig_run_ff;
   end

   assign accept         = req_valid && !req_stall;
   assign trig_req.start = trig_start;
   assign trig_req.angle = (state_ff == kcpi_pkg::ST_TRIG_H) ? cur_head_ff : cur_tire_ff;

   // Shared multiplier operands by step
   always_comb begin
      case (mul_step_ff)
         3'd0: begin
            mul_a = $signed({17'b0, dur_ff});
            mul_b = $signed({{9{op_speed_ff[23]}}, op_speed_ff});
         end
         3'd1: begin
            mul_a = $signed({17'b0, dur_ff});
            mul_b = $signed({{9{op_rate_ff[23]}}, op_rate_ff});
         end
         3'd2: begin
            mul_a = $signed({{8{dv_ff[24]}}, dv_ff});
            mul_b = $signed({9'b0, inv_wb_ff});
         end
         3'd3: begin
            mul_a = $signed({{8{dv_ff[24]}}, dv_ff});
            mul_b = ct_ff;
         end
         3'd4: begin
            mul_a = dvl_ff;
            mul_b = st_ff;
         end
         3'd5: begin
            mul_a = $signed({{6{dvc_ff[26]}}, dvc_ff});
            mul_b = ch_ff;
         end
         3'd6: begin
            mul_a = $signed({{6{dvc_ff[26]}}, dvc_ff});
            mul_b = sh_ff;
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   // Round half up and saturating pose sums
   assign r16      = (prod_ff + 66'sd32768) >>> 16;
   assign r30      = (prod_ff + 66'sd536870912) >>> 30;
   assign dy       = r30[27:0];
   assign sum_x    = {{2{cur_x_ff[31]}}, cur_x_ff} + {{6{dx_ff[27]}}, dx_ff};
   assign sum_y    = {{2{cur_y_ff[31]}}, cur_y_ff} + {{6{dy[27]}}, dy};
   assign sum_tire = {{10{cur_tire_ff[23]}}, cur_tire_ff} + {{9{dr_ff[24]}}, dr_ff};
   assign sum_head = {{10{cur_head_ff[23]}}, cur_head_ff} + {dh_ff[32], dh_ff};
   assign sum_time = {1'b0, cur_time_ff} + {17'b0, dur_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kcpi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_wb_ff  <= kcpi_pkg::RST_INV_WHEELBASE;
         min_dur_ff <= kcpi_pkg::RST_MIN_DURATION;
         max_dur_ff <= kcpi_pkg::RST_MAX_DURATION;
         fin_dur_ff <= kcpi_pkg::RST_FINAL_DURATION;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kcpi_pkg::CSR_INV_WHEELBASE:  inv_wb_ff  <= csr_wdata[23:0];
            kcpi_pkg::CSR_MIN_DURATION:   min_dur_ff <= csr_wdata[15:0];
            kcpi_pkg::CSR_MAX_DURATION:   max_dur_ff <= csr_wdata[15:0];
            kcpi_pkg::CSR_FINAL_DURATION: fin_dur_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Capture the accepted command
   always_ff @(posedge clock) begin
      if (accept) begin
         in_time_ff  <= req_command_time;
         in_speed_ff <= req_speed;
         in_rate_ff  <= req_steer_rate;
         in_fin_ff   <= req_final_command;
      end
   end

   // CORDIC launch flag and captured results
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_run_ff <= 1'b0;
      end else if (trig_start) begin
         trig_run_ff <= 1'b1;
      end else if (trig_rsp.done) begin
         trig_run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (trig_rsp.done && state_ff == kcpi_pkg::ST_TRIG_T) begin
         st_ff <= trig_rsp.sin_v;
         ct_ff <= trig_rsp.cos_v;
      end
      if (trig_rsp.done && state_ff == kcpi_pkg::ST_TRIG_H) begin
         sh_ff <= trig_rsp.sin_v;
         ch_ff <= trig_rsp.cos_v;
      end
   end

   // Multiply, then write back the rounded product from the product register
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == kcpi_pkg::ST_MUL) begin
         mul_step_ff <= mul_step_ff + 3'd1;
         case (mul_step_ff)
            3'd1: dv_ff  <= r16[24:0];
            3'd2: dr_ff  <= r16[24:0];
            3'd3: dvl_ff <= r16[32:0];
            3'd4: dvc_ff <= r30[26:0];
            3'd5: dh_ff  <= r30[32:0];
            3'd6: dx_ff  <= r30[27:0];
            default: begin
            end
         endcase
      end else begin
         mul_step_ff <= 3'd0;
      end
   end

   // Pending command, pose and operand selection
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_time_ff  <= 32'd0;
         pend_speed_ff <= 24'sd0;
         pend_rate_ff  <= 24'sd0;
         cur_time_ff   <= 32'd0;
         cur_x_ff      <= 32'sd0;
         cur_y_ff      <= 32'sd0;
         cur_tire_ff   <= 24'sd0;
         cur_head_ff   <= 24'sd0;
         phase_ff      <= 1'b0;
         bad_ff        <= 1'b0;
      end else begin
         case (state_ff)
            kcpi_pkg::ST_CHECK: begin
               bad_ff <= 1'b0;
               if (pend_valid_ff) begin
                  phase_ff    <= 1'b0;
                  dur_ff      <= gap[15:0];
                  op_speed_ff <= pend_speed_ff;
                  op_rate_ff  <= pend_rate_ff;
                  if (gap_bad) begin
                     bad_ff      <= 1'b1;
                     cur_time_ff <= 32'd0;
                     cur_x_ff    <= 32'sd0;
                     cur_y_ff    <= 32'sd0;
                     cur_tire_ff <= 24'sd0;
                     cur_head_ff <= 24'sd0;
                  end
               end else if (in_fin_ff) begin
                  phase_ff    <= 1'b1;
                  dur_ff      <= fin_dur_ff;
                  op_speed_ff <= in_speed_ff;
                  op_rate_ff  <= in_rate_ff;
               end else begin
                  pend_valid_ff <= 1'b1;
                  pend_time_ff  <= in_time_ff;
                  pend_speed_ff <= in_speed_ff;
                  pend_rate_ff  <= in_rate_ff;
               end
            end
            kcpi_pkg::ST_MUL: begin
               if (mul_step_ff == kcpi_pkg::MUL_LAST) begin
                  cur_x_ff    <= kcpi_pkg::sat32(sum_x);
                  cur_y_ff    <= kcpi_pkg::sat32(sum_y);
                  cur_tire_ff <= kcpi_pkg::sat24(sum_tire);
                  cur_head_ff <= kcpi_pkg::sat24(sum_head);
                  cur_time_ff <= sum_time[32] ? 32'hFFFF_FFFF : sum_time[31:0];
               end
            end
            kcpi_pkg::ST_EMIT: begin
               if (emit_load) begin
                  if (phase_ff) begin
                     pend_valid_ff <= 1'b0;
                  end else if (in_fin_ff) begin
                     // run the final command next
                     phase_ff      <= 1'b1;
                     bad_ff        <= 1'b0;
                     pend_valid_ff <= 1'b0;
                     dur_ff        <= fin_dur_ff;
                     op_speed_ff   <= in_speed_ff;
                     op_rate_ff    <= in_rate_ff;
                  end else begin
                     pend_valid_ff <= 1'b1;
                     pend_time_ff  <= in_time_ff;
                     pend_speed_ff <= in_speed_ff;
                     pend_rate_ff  <= in_rate_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Output register: load a result, drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_time_ff <= cur_time_ff;
         rsp_x_ff    <= cur_x_ff;
         rsp_y_ff    <= cur_y_ff;
         rsp_tire_ff <= cur_tire_ff;
         rsp_head_ff <= cur_head_ff;
         rsp_bad_ff  <= bad_ff;
         rsp_last_ff <= phase_ff || !in_fin_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pose_time   = rsp_time_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_steer_angle = rsp_tire_ff;
   assign rsp_heading     = rsp_head_ff;
   assign rsp_bad_gap     = rsp_bad_ff;
   assign rsp_end_of_run  = rsp_last_ff;

`ifndef SYNTHESIS
   a_bad_clears_pose: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_gap) |-> (rsp_pose_time == 32'd0 && rsp_pos_x == 32'sd0 &&
                                      rsp_pos_y == 32'sd0 && rsp_heading == 24'sd0))
      else $error("bad gap result carries a pose");

   a_trig_in_trig_state: assert property (@(posedge clock) disable iff (reset)
      trig_run_ff |-> (state_ff == kcpi_pkg::ST_TRIG_T || state_ff == kcpi_pkg::ST_TRIG_H))
      else $error("trig unit running outside a trig state");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == kcpi_pkg::ST_EMIT))
      else $error("result loaded outside the emit state");

   a_final_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (emit_load && phase_ff) |=> !pend_valid_ff)
      else $error("pending command kept after a final command");
`endif

endmodule

// ===== sim/kinematic_car_pose_integrator_tb.sv =====
module kinematic_car_pose_integrator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 200;

   typedef struct packed {
      logic [31:0]        pose_time;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [23:0] steer_angle;
      logic signed [23:0] heading;
      logic               bad_gap;
      logic               end_of_run;
   } pose_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [31:0]        req_command_time;
   logic signed [23:0] req_speed;
   logic signed [23:0] req_steer_rate;
   logic               req_final_command;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [31:0]        rsp_pose_time;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [23:0] rsp_steer_angle;
   logic signed [23:0] rsp_heading;
   logic               rsp_bad_gap;
   logic               rsp_end_of_run;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_index;
   logic [31:0]        csr_wdata;

   // predictor state and register copies
   logic [23:0] wheel_inv;
   logic [15:0] gap_min, gap_max, gap_final;
   logic        held_valid;
   logic [31:0] held_time, pose_clock;
   longint      held_speed, held_rate;
   longint      pose_x, pose_y, pose_tire, pose_heading;

   pose_type    pose_queue[$];
   int          error_count;
   int          idle_count;
   int          send_idle_pct, recv_idle_pct;
   int          trig_steps;

   kinematic_car_pose_integrator uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint shift_down(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_w(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // rotation-mode CORDIC on a Q8.16 angle, results in Q2.30
   task automatic cordic_sincos(input longint ang, output longint s, output longint c);
      longint z, x, y, nx;
      longint atan_tab[24];
      bit     flip;
      atan_tab = '{843314857, 497837830, 263043837, 133525159, 67021687,
                   33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                   524288, 262144, 131072, 65536, 32768, 16384, 8192,
                   4096, 2048, 1024, 512, 256, 128};
      z = (ang * 16384) % 64'sd6746518852;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 64'sd3373259426) z -= 64'sd6746518852;
      if (z < -64'sd3373259426) z += 64'sd6746518852;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426;
         flip = 1'b1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426;
         flip = 1'b1;
      end
      for (int i = 0; i < trig_steps; i++) begin
         if (z >= 0) begin
            nx = x - shift_down(y, i); y = y + shift_down(x, i); z -= atan_tab[i];
         end else begin
            nx = x + shift_down(y, i); y = y - shift_down(x, i); z += atan_tab[i];
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   // one Euler step of the bicycle model
   task automatic euler_step(input longint d, input longint v, input longint rate);
      longint st, ct, sh, ch, dv, dvl, dvc, t;
      cordic_sincos(pose_tire, st, ct);
      cordic_sincos(pose_heading, sh, ch);
      dv  = round_q(d * v, 16);
      dvl = round_q(dv * longint'(wheel_inv), 16);
      dvc = round_q(dv * ct, 30);
      pose_x       = clamp_w(pose_x + round_q(dvc * ch, 30), 32);
      pose_y       = clamp_w(pose_y + round_q(dvc * sh, 30), 32);
      pose_heading = clamp_w(pose_heading + round_q(dvl * st, 30), 24);
      pose_tire    = clamp_w(pose_tire + round_q(d * rate, 16), 24);
      t = longint'(pose_clock) + d;
      pose_clock = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
   endtask

   task automatic push_pose(input bit bad, input bit last);
      pose_type p;
      p.pose_time   = pose_clock;
      p.pos_x       = pose_x[31:0];
      p.pos_y       = pose_y[31:0];
      p.steer_angle = pose_tire[23:0];
      p.heading     = pose_heading[23:0];
      p.bad_gap     = bad;
      p.end_of_run  = last;
      pose_queue.insert(pose_queue.size(), p);
   endtask

   // work out the poses caused by one accepted command
   task automatic predict_command(input logic [31:0] t, input logic signed [23:0] v,
                                  input logic signed [23:0] r, input logic fin);
      longint gap;
      bit     bad;
      if (held_valid) begin
         gap = longint'(t) - longint'(held_time);
         bad = (gap < longint'(gap_min)) || (gap > longint'(gap_max));
         if (bad) begin
            pose_x = 0; pose_y = 0; pose_tire = 0; pose_heading = 0; pose_clock = 0;
         end else begin
            euler_step(gap, held_speed, held_rate);
         end
         push_pose(bad, !fin);
      end
      if (fin) begin
         euler_step(longint'(gap_final), longint'(v), longint'(r));
         push_pose(1'b0, 1'b1);
         held_valid = 1'b0;
      end else begin
         held_valid = 1'b1;
         held_time  = t;
         held_speed = v;
         held_rate  = r;
      end
   endtask

   // send one command and wait for its transfer; valid drops when the sender idles
   task automatic send_command(input logic [31:0] t, input logic signed [23:0] v,
                               input logic signed [23:0] r, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_command_time  <= t;
      req_speed         <= v;
      req_steer_rate    <= r;
      req_final_command <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(t, v, r, fin);
      @(negedge clock);
   endtask

   // drop valid, wait for all poses to drain, then let the block settle
   task automatic drain_poses();
      req_valid <= 1'b0;
      while (pose_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [7:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         kcpi_pkg::CSR_INV_WHEELBASE:  wheel_inv = data[23:0];
         kcpi_pkg::CSR_MIN_DURATION:   gap_min   = data[15:0];
         kcpi_pkg::CSR_MAX_DURATION:   gap_max   = data[15:0];
         kcpi_pkg::CSR_FINAL_DURATION: gap_final = data[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_registers(input logic [23:0] iw, input logic [15:0] mn,
                                input logic [15:0] mx, input logic [15:0] fd);
      drain_poses();
      write_register(kcpi_pkg::CSR_INV_WHEELBASE, {8'hA5, iw});
      write_register(kcpi_pkg::CSR_MIN_DURATION, {16'h5A5A, mn});
      write_register(kcpi_pkg::CSR_MAX_DURATION, {16'hFFFF, mx});
      write_register(kcpi_pkg::CSR_FINAL_DURATION, {16'h0, fd});
      csr_valid <= 1'b0;
   endtask

   // directed: first command, bad gaps, extremes, final commands
   task automatic test_directed();
      send_command(32'd0, 24'sd0, 24'sd0, 1'b1);
      send_command(32'd100, 24'sd65536, 24'sd6554, 1'b0);
      send_command(32'd1000, 24'sd65536, 24'sd6554, 1'b0);
      send_command(32'd500, 24'sd131072, -24'sd6554, 1'b0);
      send_command(32'd13607, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
      send_command(32'd26714, 24'h800000, 24'h800000, 1'b0);
      send_command(32'd26714 + 32'd328, -24'sd1, 24'sd1, 1'b0);
      send_command(32'd27042 + 32'd327, 24'sd0, 24'sd0, 1'b0);
      send_command(32'hFFFF_FFFF, 24'h7FFFFF, 24'h800000, 1'b0);
      send_command(32'hFFFF_FFFF, 24'sd655360, 24'sd0, 1'b1);
      send_command(32'h8000_0000, 24'h555555, 24'hAAAAAA, 1'b0);
      send_command(32'h8000_0000 + 32'd13107, 24'hAAAAAA, 24'h555555, 1'b1);
   endtask

   // random runs: mostly well-formed gaps, some broken ones
   task automatic test_random_runs(input int count);
      logic [31:0] t;
      logic [31:0] step;
      int          kind;
      t = $urandom;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 75)
            step = $urandom_range(gap_max, gap_min);
         else if (kind < 85)
            step = $urandom_range(gap_min + 1, 0);
         else if (kind < 95)
            step = gap_max + $urandom_range(2000, 1);
         else
            step = $urandom;
         if (gap_min > gap_max) step = $urandom_range(20000);
         t = t + step;
         send_command(t, 24'((kind < 50) ? $urandom_range(400000) - 200000 : $urandom),
                      24'((kind < 60) ? $urandom_range(200000) - 100000 : $urandom),
                      $urandom_range(19) == 0);
      end
   endtask

   // register sweep including the extremes
   task automatic test_register_settings();
      set_registers(24'hFFFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
      test_random_runs(60);
      set_registers(24'd0, 16'hFFFF, 16'd0, 16'd0);
      test_random_runs(20);
      set_registers(24'd131072, 16'd100, 16'd4000, 16'd1000);
      test_random_runs(60);
      set_registers(24'd26214, 16'd328, 16'd13107, 16'd13107);
      drain_poses();
      write_register(8'hC3, 32'hDEAD_BEEF);
      csr_valid <= 1'b0;
   endtask

   // compare each pose transfer with the oldest expectation
   always @(posedge clock) begin
      pose_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_pose_time, rsp_pos_x, rsp_pos_y, rsp_steer_angle, rsp_heading,
                 rsp_bad_gap, rsp_end_of_run};
         if (pose_queue.size() == 0) begin
            $display("%0t: unexpected pose transfer, actual %h", $time, got);
            error_count++;
         end else begin
            want = pose_queue.pop_front();
            if (got.pose_time !== want.pose_time)
               $display("%0t: pose_time expected %h actual %h", $time, want.pose_time,
                        got.pose_time);
            if (got.pos_x !== want.pos_x)
               $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
            if (got.pos_y !== want.pos_y)
               $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
            if (got.steer_angle !== want.steer_angle)
               $display("%0t: steer_angle expected %h actual %h", $time, want.steer_angle,
                        got.steer_angle);
            if (got.heading !== want.heading)
               $display("%0t: heading expected %h actual %h", $time, want.heading,
                        got.heading);
            if (got.bad_gap !== want.bad_gap)
               $display("%0t: bad_gap expected %b actual %b", $time, want.bad_gap,
                        got.bad_gap);
            if (got.end_of_run !== want.end_of_run)
               $display("%0t: end_of_run expected %b actual %b", $time, want.end_of_run,
                        got.end_of_run);
            if (got !== want) error_count++;
         end
      end
   end

   // drive receiver stalls at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // end the run when nothing transfers for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      trig_steps = kcpi_pkg::TRIG_STEPS;
      send_idle_pct = 24;
      recv_idle_pct = 51;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command_time = '0;
      req_speed = '0;
      req_steer_rate = '0;
      req_final_command = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      wheel_inv = 24'd26214;
      gap_min = 16'd328;
      gap_max = 16'd13107;
      gap_final = 16'd13107;
      held_valid = 1'b0;
      held_time = 0; held_speed = 0; held_rate = 0;
      pose_x = 0; pose_y = 0; pose_tire = 0; pose_heading = 0; pose_clock = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_register_settings();
      test_random_runs(150);
      drain_poses();
      send_idle_pct = 51;
      recv_idle_pct = 24;
      test_random_runs(150);
      drain_poses();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_runs(150);
      send_command(32'd0, 24'sd0, 24'sd0, 1'b1);
      drain_poses();

      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
